FILE: sv/rfr_pkg.sv
// ----------------------------------------------------------------------------
// rfr_pkg: shared types and constants for the rational fir resampler
// widths of the word fields, codes of the item and register map, fsm states
// ----------------------------------------------------------------------------
package rfr_pkg;

    // field widths
    localparam int SAMPLE_W = 16;
    localparam int TAP_W    = 18;
    localparam int IDX_W    = 10;
    localparam int REG_W    = 11;

    // apb data and address widths, registers at 4*index
    localparam int APB_DW = 32;
    localparam int APB_AW = 4;

    // configuration ceiling for every factor
    localparam int REG_MAX = 1024;

    // datapath widths: sample scaled by L, product with a tap, window sum
    localparam int SCALED_W = SAMPLE_W + REG_W + 1;
    localparam int PROD_W   = SCALED_W + TAP_W;
    localparam int ACC_W    = 56;

    // rounding half of one q1.15 step at the q25.31 scale
    localparam int RND_HALF = 32768;

    localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 16'sh8000;

    // default sizes
    localparam int DEF_MAX_TAPS       = 1024;
    localparam int DEF_HIST_DEPTH     = 1024;
    localparam int DEF_MAX_OUT_PER_IN = 64;

    typedef enum logic [0:0] {
        OP_PUSH = 1'b0,
        OP_TAP  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        REG_INTERP = 2'd0,
        REG_DECIM  = 2'd1,
        REG_TAPS   = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_NEXT,
        S_MAC,
        S_DRAIN,
        S_EMIT
    } state_t;

    // zero acts as one, anything above the ceiling acts as the ceiling
    function automatic logic [REG_W-1:0] clamp_reg(input logic [REG_W-1:0] v);
        logic [REG_W-1:0] r;
        if (v == '0)
        begin
            r = REG_W'(1);
        end
        else if (v > REG_W'(REG_MAX))
        begin
            r = REG_W'(REG_MAX);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

FILE: sv/rfr_item_if.sv
// ----------------------------------------------------------------------------
// rfr_item_if: input channel of the resampler
// valid/ready channel carrying a sample push or a tap load
// ----------------------------------------------------------------------------
interface rfr_item_if;
    import rfr_pkg::*;

    logic                       valid;
    logic                       ready;
    op_t                        op;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic [IDX_W-1:0]           tap_index;
    logic signed [TAP_W-1:0]    tap_value;

    modport source (output valid, op, sample_in, tap_index, tap_value, input ready);
    modport sink   (input valid, op, sample_in, tap_index, tap_value, output ready);
endinterface

FILE: sv/rfr_result_if.sv
// ----------------------------------------------------------------------------
// rfr_result_if: output channel of the resampler
// valid/ready channel carrying one resampled word and its last flag
// ----------------------------------------------------------------------------
interface rfr_result_if;
    import rfr_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       last_out;

    modport source (output valid, sample_out, last_out, input ready);
    modport sink   (input valid, sample_out, last_out, output ready);
endinterface

FILE: sv/rational_fir_resampler.sv
// ----------------------------------------------------------------------------
// rational_fir_resampler: polyphase L/M fir resampler, q1.15 in and out
// taps and sample history live in two single-port-read memories; one
// multiply-accumulate per cycle walks the nonzero taps of each output window
//
//   channel  | dir | handshake            | payload
//   ---------+-----+----------------------+------------------------------------
//   item     | in  | valid/ready          | op, sample_in, tap_index, tap_value
//   result   | out | valid/ready          | sample_out, last_out
//   apb      | in  | psel/penable, pready | paddr, pwrite, pwdata, prdata
//
// a sample push walks, for each output, the nonzero taps of its window, one
// tap per cycle through the single read port of each memory; window ends
// past the output cap are skipped without a sum. history reads beyond the
// fill count count as zero, so reset needs no clearing pass. result has a
// one-word output register; a full register stalls the emit step only, and
// item is not ready during a push
// ----------------------------------------------------------------------------
module rational_fir_resampler #(
    parameter int MAX_TAPS       = rfr_pkg::DEF_MAX_TAPS,
    parameter int HIST_DEPTH     = rfr_pkg::DEF_HIST_DEPTH,
    parameter int MAX_OUT_PER_IN = rfr_pkg::DEF_MAX_OUT_PER_IN
) (
    input  logic                        clk,
    input  logic                        rst_n,
    rfr_item_if.sink                    item,
    rfr_result_if.source                result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rfr_pkg::APB_AW-1:0]  paddr,
    input  logic [rfr_pkg::APB_DW-1:0]  pwdata,
    output logic [rfr_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import rfr_pkg::*;

    localparam int TAP_AW  = $clog2(MAX_TAPS);
    localparam int HIST_AW = $clog2(HIST_DEPTH);
    localparam int CNT_W   = $clog2(HIST_DEPTH + 1);
    localparam int OUT_W   = $clog2(MAX_OUT_PER_IN + 1);
    localparam int T_LIM   = (MAX_TAPS < REG_MAX) ? MAX_TAPS : REG_MAX;

    // configuration registers and clamped factors
    logic [REG_W-1:0] interp_reg;
    logic [REG_W-1:0] decim_reg;
    logic [REG_W-1:0] taps_reg;
    logic [REG_W-1:0] l_val;
    logic [REG_W-1:0] m_val;
    logic [REG_W-1:0] t_val;
    logic [REG_W-1:0] t_m1;

    // storage
    logic signed [TAP_W-1:0]    tap_mem  [MAX_TAPS];
    logic signed [SAMPLE_W-1:0] hist_mem [HIST_DEPTH];

    // sequencer state
    state_t             state_reg, state_next;
    logic [HIST_AW-1:0] head_reg, head_next;
    logic [CNT_W-1:0]   fill_reg;
    logic [REG_W-1:0]   phase_reg;
    logic [REG_W-1:0]   s_reg;
    logic [OUT_W-1:0]   n_reg;
    logic [REG_W-1:0]   d_reg;
    logic [CNT_W-1:0]   a_reg;
    logic [HIST_AW-1:0] rp_reg;

    // mac pipeline
    logic                       v1_reg, v2_reg, v3_reg;
    logic                       z1_reg;
    logic signed [TAP_W-1:0]    tap_rd_reg;
    logic signed [SAMPLE_W-1:0] hist_rd_reg;
    logic signed [TAP_W-1:0]    tap2_reg;
    logic signed [SCALED_W-1:0] scaled_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;

    // output register
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_sample_reg;
    logic                       out_last_reg;

    // control strobes
    logic item_ready;
    logic push_acc;
    logic tap_we;
    logic issue;
    logic pipe_empty;
    logic win_start;
    logic skip_end;
    logic finish;
    logic emit_load;
    logic more_ends;
    logic below_cap;

    logic [TAP_AW-1:0]          tap_raddr;
    logic signed [SAMPLE_W-1:0] hist_eff;
    logic signed [ACC_W-1:0]    rnd_val;
    logic                       fits;
    logic signed [SAMPLE_W-1:0] sat_val;
    logic                       last_val;
    logic [REG_W:0]             phase_calc;
    logic [REG_W-1:0]           s_start;

    // apb register file
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interp_reg <= REG_W'(1);
            decim_reg  <= REG_W'(1);
            taps_reg   <= REG_W'(1);
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[3:2])
                REG_INTERP: interp_reg <= pwdata[REG_W-1:0];
                REG_DECIM:  decim_reg  <= pwdata[REG_W-1:0];
                REG_TAPS:   taps_reg   <= pwdata[REG_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_INTERP: prdata = APB_DW'(interp_reg);
            REG_DECIM:  prdata = APB_DW'(decim_reg);
            REG_TAPS:   prdata = APB_DW'(taps_reg);
            default:    prdata = '0;
        endcase
    end

    // effective factors
    always_comb
    begin
        l_val = clamp_reg(interp_reg);
        m_val = clamp_reg(decim_reg);
        t_val = clamp_reg(taps_reg);
        if (t_val > REG_W'(T_LIM))
        begin
            t_val = REG_W'(T_LIM);
        end
        t_m1 = t_val - REG_W'(1);
    end

    // control strobes
    always_comb
    begin
        item_ready = (state_reg == S_IDLE);
        push_acc   = item.valid && item_ready && (item.op == OP_PUSH);
        tap_we     = item.valid && item_ready && (item.op == OP_TAP)
                     && ({1'b0, item.tap_index} < REG_W'(T_LIM));
        more_ends  = (s_reg < l_val);
        below_cap  = (n_reg < OUT_W'(MAX_OUT_PER_IN));
        win_start  = (state_reg == S_NEXT) && more_ends && below_cap;
        skip_end   = (state_reg == S_NEXT) && more_ends && !below_cap;
        finish     = (state_reg == S_NEXT) && !more_ends;
        issue      = (state_reg == S_MAC) && (d_reg <= t_m1)
                     && (a_reg < CNT_W'(HIST_DEPTH));
        pipe_empty = !v1_reg && !v2_reg && !v3_reg;
        emit_load  = (state_reg == S_EMIT) && (!out_valid_reg || result.ready);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (push_acc)
                begin
                    state_next = S_NEXT;
                end
            end
            S_NEXT:
            begin
                if (win_start)
                begin
                    state_next = S_MAC;
                end
                else if (finish)
                begin
                    state_next = S_IDLE;
                end
            end
            S_MAC:
            begin
                if (!issue)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (pipe_empty)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (emit_load)
                begin
                    state_next = S_NEXT;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ring position of the new sample and the first window end
    always_comb
    begin
        head_next  = (head_reg == HIST_AW'(HIST_DEPTH - 1)) ? '0 : head_reg + HIST_AW'(1);
        s_start    = (phase_reg < m_val) ? (m_val - REG_W'(1) - phase_reg) : '0;
        phase_calc = {1'b0, m_val} + {1'b0, l_val} - (REG_W + 1)'(1) - {1'b0, s_reg};
        last_val   = ((s_reg + m_val) >= l_val) || (n_reg == OUT_W'(MAX_OUT_PER_IN - 1));
    end

    // sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            fill_reg  <= '0;
            phase_reg <= '0;
            s_reg     <= '0;
            n_reg     <= '0;
            d_reg     <= '0;
            a_reg     <= '0;
            rp_reg    <= '0;
        end
        else
        begin
            if (push_acc)
            begin
                head_reg <= head_next;
                if (fill_reg != CNT_W'(HIST_DEPTH))
                begin
                    fill_reg <= fill_reg + CNT_W'(1);
                end
                s_reg <= s_start;
                n_reg <= '0;
            end
            if (win_start)
            begin
                d_reg  <= s_reg;
                a_reg  <= '0;
                rp_reg <= head_reg;
            end
            if (skip_end)
            begin
                s_reg <= s_reg + m_val;
            end
            if (finish)
            begin
                phase_reg <= phase_calc[REG_W-1:0];
            end
            if (issue)
            begin
                d_reg  <= d_reg + l_val;
                a_reg  <= a_reg + CNT_W'(1);
                rp_reg <= (rp_reg == '0) ? HIST_AW'(HIST_DEPTH - 1) : rp_reg - HIST_AW'(1);
            end
            if (emit_load)
            begin
                s_reg <= s_reg + m_val;
                n_reg <= n_reg + OUT_W'(1);
            end
        end
    end

    // tap memory: loaded only while idle, read during the mac walk
    assign tap_raddr = issue ? TAP_AW'(t_m1 - d_reg) : '0;

    always_ff @(posedge clk)
    begin
        if (tap_we)
        begin
            tap_mem[TAP_AW'(item.tap_index)] <= item.tap_value;
        end
        tap_rd_reg <= tap_mem[tap_raddr];
    end

    // history memory: written on push, read newest first
    always_ff @(posedge clk)
    begin
        if (push_acc)
        begin
            hist_mem[head_next] <= item.sample_in;
        end
        hist_rd_reg <= hist_mem[rp_reg];
    end

    // pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // scale sample by L, multiply by tap, accumulate
    assign hist_eff = z1_reg ? '0 : hist_rd_reg;

    always_ff @(posedge clk)
    begin
        z1_reg     <= (a_reg >= fill_reg);
        scaled_reg <= hist_eff * $signed({1'b0, l_val});
        tap2_reg   <= tap_rd_reg;
        prod_reg   <= scaled_reg * tap2_reg;
        if (win_start)
        begin
            acc_reg <= '0;
        end
        else if (v3_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // round half up to q1.15 and saturate
    always_comb
    begin
        rnd_val = acc_reg + ACC_W'(RND_HALF);
        fits    = (rnd_val[ACC_W-1:31] == '0) || (rnd_val[ACC_W-1:31] == '1);
        sat_val = rnd_val[ACC_W-1] ? SAT_MIN : SAT_MAX;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_load)
        begin
            out_sample_reg <= fits ? rnd_val[31:16] : sat_val;
            out_last_reg   <= last_val;
        end
    end

    assign item.ready        = item_ready;
    assign result.valid      = out_valid_reg;
    assign result.sample_out = out_sample_reg;
    assign result.last_out   = out_last_reg;

`ifndef SYNTHESIS
    // products only arrive while a window is being summed
    a_acc_window: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg |-> (state_reg == S_MAC || state_reg == S_DRAIN))
        else $error("product accumulated outside a window");

    // a word is formed only from a fully drained sum
    a_emit_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (!v1_reg && !v2_reg && !v3_reg))
        else $error("emit with products still in flight");

    // phase lands below M after the last window end of a push
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> (phase_reg < m_val))
        else $error("phase offset out of range");

    // fill count saturates at the history depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(HIST_DEPTH))
        else $error("history fill count overflow");
`endif

endmodule
